// ===== hdl/qcjk_pkg.sv =====
// Shared types and constants of the quoted CJK word extractor.
// No dependencies; qcjk_front, qcjk_back and the top level import this package.
`timescale 1ns / 1ps

package qcjk_pkg;

  // Register indexes of the configuration port
  localparam logic REG_MIN_CHARS = 1'b0;
  localparam logic REG_MAX_CHARS = 1'b1;

  // Register reset values
  localparam logic [3:0] MIN_CHARS_RESET = 4'd3;
  localparam logic [3:0] MAX_CHARS_RESET = 4'd8;

  // Accepted code range of a 3-byte character, and the byte codes
  localparam logic [23:0] CJK_LOW   = 24'hE4B880;
  localparam logic [23:0] CJK_HIGH  = 24'hE9BFA6;
  localparam logic [7:0]  QUOTE     = 8'h22;
  localparam logic [7:0]  LEAD4_PAT = 8'hF0;
  localparam logic [7:0]  LEAD3_PAT = 8'hE0;
  localparam logic [7:0]  LEAD2_PAT = 8'hC0;

  // Largest count shown on the output
  localparam logic [3:0] SHOWN_MAX = 4'd15;

  // Parser phase within one cell
  typedef enum logic [1:0] {
    PH_WAIT,
    PH_IN,
    PH_CLOSED,
    PH_REJECT
  } phase_t;

  // Back-end sequencer state
  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SEND
  } bstate_t;

  // Event passed from front to back for one input byte
  typedef struct packed {
    logic        has_char;  // a character completes and is to be stored
    logic        has_end;   // the cell ends with this byte
    logic        ok;        // the cell yields an accepted word
    logic [23:0] code;      // completed character code
  } cell_ev_t;

endpackage

// ===== hdl/qcjk_fifo.sv =====
// Short register queue between the parser front end and the emitting back end.
// Generic payload; depends on nothing else.
`timescale 1ns / 1ps

module qcjk_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CNTW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNTW'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - CNTW'(1);
      end
    end
  end

endmodule

// ===== hdl/qcjk_front.sv =====
// Byte parser: classifies UTF-8 bytes of a cell, counts characters, decides the cell.
// Depends on qcjk_pkg.
`timescale 1ns / 1ps

module qcjk_front
  import qcjk_pkg::*;
#(
  parameter int WORD_CHARS_MAX = 8,
  parameter int SW = 3,
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data,
  // byte input
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_end,
  output logic          in_ready,
  // event output towards the queue
  output logic          ev_push,
  output cell_ev_t      ev,
  output logic [SW-1:0] ev_slot,
  output logic [CW-1:0] ev_count,
  output logic [3:0]    ev_shown,
  input  logic          ev_full
);

  localparam int CMW = (CW > 4) ? CW : 4;

  logic [3:0]    min_chars;
  logic [3:0]    max_chars;
  phase_t        phase, phase_next;
  logic [1:0]    skip_left, skip_left_next;
  logic [1:0]    collect_left, collect_left_next;
  logic [23:0]   code_accum, code_accum_next;
  logic [CW-1:0] char_counter, char_counter_next;
  logic          char_store;
  logic [CMW-1:0] cnt_ext;
  logic          take;

  assign in_ready = !ev_full;
  assign take     = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_chars <= MIN_CHARS_RESET;
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_CHARS: min_chars <= cfg_data;
        REG_MAX_CHARS: max_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parse one byte
  always_comb begin
    phase_next        = phase;
    skip_left_next    = skip_left;
    collect_left_next = collect_left;
    code_accum_next   = code_accum;
    char_counter_next = char_counter;
    char_store        = 1'b0;
    if (phase == PH_CLOSED || phase == PH_REJECT) begin
      // ignore the rest of the cell
    end else if (skip_left != 2'd0) begin
      skip_left_next = skip_left - 2'd1;
    end else if (collect_left != 2'd0) begin
      code_accum_next   = {code_accum[15:0], in_byte};
      collect_left_next = collect_left - 2'd1;
      if (collect_left == 2'd1) begin
        if (code_accum_next >= CJK_LOW && code_accum_next <= CJK_HIGH) begin
          char_store = (char_counter < CW'(WORD_CHARS_MAX));
          if (char_counter < CW'(WORD_CHARS_MAX + 1)) begin
            char_counter_next = char_counter + CW'(1);
          end
        end else begin
          phase_next = PH_REJECT;
        end
      end
    end else begin
      priority if ((in_byte & LEAD4_PAT) == LEAD4_PAT) begin
        skip_left_next = 2'd3;
      end else if ((in_byte & LEAD3_PAT) == LEAD3_PAT) begin
        if (phase == PH_WAIT) begin
          phase_next = PH_REJECT;
        end else begin
          code_accum_next   = {16'h0000, in_byte};
          collect_left_next = 2'd2;
        end
      end else if ((in_byte & LEAD2_PAT) == LEAD2_PAT) begin
        skip_left_next = 2'd1;
      end else if (in_byte == QUOTE) begin
        phase_next = (phase == PH_WAIT) ? PH_IN : PH_CLOSED;
      end else begin
        // plain single byte, stray continuation bytes included: no change
      end
    end
  end

  // Decide the cell on its last byte
  assign cnt_ext       = CMW'(char_counter_next);
  assign ev.has_char   = char_store;
  assign ev.has_end    = in_end;
  assign ev.code       = code_accum_next;
  assign ev.ok         = (phase_next == PH_CLOSED) && (char_counter_next != '0) &&
                         (char_counter_next <= CW'(WORD_CHARS_MAX)) &&
                         (cnt_ext >= CMW'(min_chars)) && (cnt_ext <= CMW'(max_chars));
  assign ev_slot       = SW'(char_counter);
  assign ev_count      = char_counter_next;
  assign ev_shown      = (cnt_ext > CMW'(SHOWN_MAX)) ? SHOWN_MAX : 4'(char_counter_next);
  assign ev_push       = take && (char_store || in_end);

  // Hold parser state; clear it at the end of each cell
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      skip_left    <= 2'd0;
      collect_left <= 2'd0;
      code_accum   <= 24'h0;
      char_counter <= '0;
    end else if (take) begin
      if (in_end) begin
        phase        <= PH_WAIT;
        skip_left    <= 2'd0;
        collect_left <= 2'd0;
        code_accum   <= 24'h0;
        char_counter <= '0;
      end else begin
        phase        <= phase_next;
        skip_left    <= skip_left_next;
        collect_left <= collect_left_next;
        code_accum   <= code_accum_next;
        char_counter <= char_counter_next;
      end
    end
  end

endmodule

// ===== hdl/qcjk_back.sv =====
// Back end: stores characters in the word memory and emits results through an output register.
// Depends on qcjk_pkg.
`timescale 1ns / 1ps

module qcjk_back
  import qcjk_pkg::*;
#(
  parameter int WORD_CHARS_MAX = 8,
  parameter int SW = 3,
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          rst,
  // event input from the queue
  input  logic          ev_avail,
  input  cell_ev_t      ev,
  input  logic [SW-1:0] ev_slot,
  input  logic [CW-1:0] ev_count,
  input  logic [3:0]    ev_shown,
  output logic          ev_pop,
  // result output
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          word_valid,
  output logic [3:0]    char_count,
  output logic          last_of_run
);

  logic [23:0]   word_mem [WORD_CHARS_MAX];
  logic [23:0]   rd_data;
  bstate_t       state, state_next;
  logic [SW-1:0] char_idx, char_idx_next;
  logic [1:0]    byte_idx, byte_idx_next;
  logic [CW-1:0] word_len, word_len_next;
  logic [3:0]    shown, shown_next;
  logic          out_free;
  logic          load;
  logic          mem_we;
  logic          ld_byte_sel;
  logic [7:0]    ld_byte;
  logic          ld_word;
  logic          ld_last;
  logic          last_char;

  assign out_free  = !out_valid || out_ready;
  assign last_char = (CW'(char_idx) + CW'(1)) == word_len;

  // Word memory: one character per entry, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[ev_slot] <= ev.code;
    end
    rd_data <= word_mem[char_idx];
  end

  // Pick the byte of the current character
  always_comb begin
    unique case (byte_idx)
      2'd0:    ld_byte = rd_data[23:16];
      2'd1:    ld_byte = rd_data[15:8];
      default: ld_byte = rd_data[7:0];
    endcase
  end

  // Sequence events and emission
  always_comb begin
    state_next    = state;
    char_idx_next = char_idx;
    byte_idx_next = byte_idx;
    word_len_next = word_len;
    shown_next    = shown;
    ev_pop        = 1'b0;
    mem_we        = 1'b0;
    load          = 1'b0;
    ld_byte_sel   = 1'b0;
    ld_word       = 1'b0;
    ld_last       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (ev_avail && (!ev.has_end || ev.ok || out_free)) begin
          ev_pop = 1'b1;
          mem_we = ev.has_char;
          if (ev.has_end) begin
            shown_next = ev_shown;
            if (ev.ok) begin
              word_len_next = ev_count;
              char_idx_next = '0;
              state_next    = B_FETCH;
            end else begin
              load    = 1'b1;
              ld_last = 1'b1;
            end
          end
        end
      end
      B_FETCH: begin
        byte_idx_next = 2'd0;
        state_next    = B_SEND;
      end
      B_SEND: begin
        if (out_free) begin
          load        = 1'b1;
          ld_byte_sel = 1'b1;
          ld_word     = 1'b1;
          ld_last     = (byte_idx == 2'd2) && last_char;
          if (byte_idx == 2'd2) begin
            if (last_char) begin
              state_next = B_IDLE;
            end else begin
              char_idx_next = char_idx + SW'(1);
              state_next    = B_FETCH;
            end
          end else begin
            byte_idx_next = byte_idx + 2'd1;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
    char_idx <= char_idx_next;
    byte_idx <= byte_idx_next;
    word_len <= word_len_next;
    shown    <= shown_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= ld_byte_sel ? ld_byte : 8'h00;
      word_valid  <= ld_word;
      char_count  <= shown_next;
      last_of_run <= ld_last;
    end
  end

endmodule

// ===== hdl/quoted_cjk_word_extractor_unit.sv =====
// Top level of the quoted CJK word extractor: parser front, event queue, emitting back end.
// Depends on qcjk_pkg, qcjk_front, qcjk_fifo and qcjk_back.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------------
//  s_       | in        | s_tvalid/s_tready | tdata: cell_byte; tlast: end_of_cell
//  m_       | out       | m_tvalid/m_tready | tdata: out_byte, char_count; tuser: word_valid;
//           |           |                   | tlast: last_of_run
//  cfg_     | in        | cfg_we            | cfg_index, cfg_data (min_chars, max_chars)
//
//  The front end takes one byte per cycle while the event queue has room.
//  The back end takes queued events in its idle state; an accepted word is
//  emitted character by character, a memory fetch and three byte sends each;
//  a reject is a single closing result. Reset is synchronous and clears all
//  control state but the back-end indexes and lengths; no clearing pass is run.
//  A stall on m_ stops the back end only; s_ stalls once the queue is full.

module quoted_cjk_word_extractor_unit
  import qcjk_pkg::*;
#(
  parameter int WORD_CHARS_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  // byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] cell_byte
  input  logic        s_tlast,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] char_count, [15:12] zero
  output logic        m_tuser,   // [0] word_valid
  output logic        m_tlast
);

  localparam int SW = (WORD_CHARS_MAX > 1) ? $clog2(WORD_CHARS_MAX) : 1;
  localparam int CW = $clog2(WORD_CHARS_MAX + 2);
  localparam int EVW = $bits(cell_ev_t);
  localparam int QW = EVW + SW + CW + 4;

  logic          f_push;
  cell_ev_t      f_ev;
  logic [SW-1:0] f_slot;
  logic [CW-1:0] f_count;
  logic [3:0]    f_shown;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic [QW-1:0] q_out;
  cell_ev_t      b_ev;
  logic [SW-1:0] b_slot;
  logic [CW-1:0] b_count;
  logic [3:0]    b_shown;
  logic [7:0]    out_byte;
  logic [3:0]    char_count;

  qcjk_front #(
    .WORD_CHARS_MAX(WORD_CHARS_MAX),
    .SW(SW),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(s_tvalid),
    .in_byte(s_tdata),
    .in_end(s_tlast),
    .in_ready(s_tready),
    .ev_push(f_push),
    .ev(f_ev),
    .ev_slot(f_slot),
    .ev_count(f_count),
    .ev_shown(f_shown),
    .ev_full(q_full)
  );

  qcjk_fifo #(
    .WIDTH(QW),
    .DEPTH(4)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .push_data({f_shown, f_count, f_slot, f_ev}),
    .full(q_full),
    .pop(q_pop),
    .pop_data(q_out),
    .empty(q_empty)
  );

  assign {b_shown, b_count, b_slot, b_ev} = q_out;

  qcjk_back #(
    .WORD_CHARS_MAX(WORD_CHARS_MAX),
    .SW(SW),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .ev_avail(!q_empty),
    .ev(b_ev),
    .ev_slot(b_slot),
    .ev_count(b_count),
    .ev_shown(b_shown),
    .ev_pop(q_pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_byte(out_byte),
    .word_valid(m_tuser),
    .char_count(char_count),
    .last_of_run(m_tlast)
  );

  assign m_tdata = {4'h0, char_count, out_byte};

endmodule

// ===== hdl/qcjk_checker.sv =====
// Port-level checks on the result stream of the quoted CJK word extractor.
// Depends on the top level's ports only; bound to quoted_cjk_word_extractor_unit below.
`timescale 1ns / 1ps

module qcjk_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled request stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result request dropped while stalled");

  // A reject is a single, closing request with a zero byte
  a_reject_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
    else $error("reject request malformed");

  // Word bytes always carry a non-zero count
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[11:8] != 4'h0))
    else $error("word byte with zero count");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:12] == 4'h0))
    else $error("padding bits set");

endmodule

bind quoted_cjk_word_extractor_unit qcjk_checker u_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);
